// ===== rtl/core/u8l1_pkg.sv =====
package u8l1_pkg;

    localparam int unsigned ByteW   = 8;
    localparam int unsigned CharW   = 8;
    localparam int unsigned LenW    = 3;
    localparam int unsigned OnesW   = 4;
    localparam int unsigned PayW    = 6;
    localparam int unsigned MaxSeqBytesDefault = 4;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_LONG = 2'd1,
        ST_ABOVE_FF = 2'd2,
        ST_STRAY    = 2'd3
    } t_status;

    typedef struct packed {
        logic [CharW-1:0] latin1_char;
        logic [LenW-1:0]  seq_length;
        t_status          status;
    } t_result;

    typedef struct packed {
        logic    emit;
        t_result result;
    } t_dec_out;

    // Count the run of ones from the most significant bit down.
    function automatic logic [OnesW-1:0] lead_ones(input logic [ByteW-1:0] b);
        logic [OnesW-1:0] n;
        logic             run;
        n   = '0;
        run = 1'b1;
        for (int i = ByteW - 1; i >= 0; i--) begin
            run = run & b[i];
            if (run) begin
                n = n + OnesW'(1);
            end
        end
        return n;
    endfunction

endpackage

// ===== rtl/core/u8l1_byte_if.sv =====
interface u8l1_byte_if;
    logic                          valid;
    logic                          ready;
    logic [u8l1_pkg::ByteW-1:0]    byte_in;

    modport source (output valid, output byte_in, input ready);
    modport sink   (input valid, input byte_in, output ready);
endinterface

// ===== rtl/core/u8l1_char_if.sv =====
interface u8l1_char_if;
    logic                          valid;
    logic                          ready;
    logic [u8l1_pkg::CharW-1:0]    latin1_char;
    logic [u8l1_pkg::LenW-1:0]     seq_length;
    logic [1:0]                    status;

    modport source (output valid, output latin1_char, output seq_length, output status,
                    input ready);
    modport sink   (input valid, input latin1_char, input seq_length, input status,
                    output ready);
endinterface

// ===== rtl/core/u8l1_in_reg.sv =====
module u8l1_in_reg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    u8l1_byte_if.sink                  i_in,
    input  logic                       i_adv,
    output logic                       o_valid,
    output logic [u8l1_pkg::ByteW-1:0] o_byte
);

    logic                       r_valid;
    logic [u8l1_pkg::ByteW-1:0] r_byte;
    logic                       w_take;

    // Free slot when empty or when the held word moves on this cycle.
    assign i_in.ready = !r_valid || i_adv;
    assign w_take     = i_in.valid && i_in.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
        if (w_take) begin
            r_byte <= i_in.byte_in;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== rtl/core/u8l1_decode.sv =====
module u8l1_decode #(
    parameter int unsigned MAX_SEQ_BYTES = u8l1_pkg::MaxSeqBytesDefault
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    input  logic [u8l1_pkg::ByteW-1:0] i_byte,
    output u8l1_pkg::t_dec_out         o_dec
);

    localparam int unsigned RemW   = $clog2(MAX_SEQ_BYTES);
    localparam int unsigned ShiftW = u8l1_pkg::CharW + u8l1_pkg::PayW;

    logic [RemW-1:0]                r_rem,   n_rem;
    logic [u8l1_pkg::CharW-1:0]     r_acc,   n_acc;
    logic                           r_big,   n_big;
    logic [u8l1_pkg::LenW-1:0]      r_total, n_total;

    logic [u8l1_pkg::OnesW-1:0]     w_ones;
    logic [ShiftW-1:0]              w_shift;
    logic [u8l1_pkg::CharW-1:0]     w_lead_mask;
    logic                           w_big;

    assign w_ones      = u8l1_pkg::lead_ones(i_byte);
    assign w_shift     = {r_acc, i_byte[u8l1_pkg::PayW-1:0]};
    // Bits above the low byte only ever move up, so a sticky flag tracks them.
    assign w_big       = r_big || (|w_shift[ShiftW-1:u8l1_pkg::CharW]);
    assign w_lead_mask = u8l1_pkg::CharW'(8'h7F >> w_ones);

    always_comb begin
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_big   = r_big;
        n_total = r_total;
        o_dec   = '0;
        if (r_rem != '0) begin
            n_rem = r_rem - RemW'(1);
            n_acc = w_shift[u8l1_pkg::CharW-1:0];
            n_big = w_big;
            if (r_rem == RemW'(1)) begin
                o_dec.emit              = 1'b1;
                o_dec.result.seq_length = r_total;
                if (w_big) begin
                    o_dec.result.status = u8l1_pkg::ST_ABOVE_FF;
                end else begin
                    o_dec.result.status      = u8l1_pkg::ST_OK;
                    o_dec.result.latin1_char = w_shift[u8l1_pkg::CharW-1:0];
                end
                n_acc   = '0;
                n_big   = 1'b0;
                n_total = '0;
            end
        end else begin
            if (w_ones == '0) begin
                o_dec.emit               = 1'b1;
                o_dec.result.latin1_char = i_byte;
                o_dec.result.seq_length  = u8l1_pkg::LenW'(1);
                o_dec.result.status      = u8l1_pkg::ST_OK;
            end else if (w_ones == u8l1_pkg::OnesW'(1)) begin
                o_dec.emit              = 1'b1;
                o_dec.result.seq_length = u8l1_pkg::LenW'(1);
                o_dec.result.status     = u8l1_pkg::ST_STRAY;
            end else if (w_ones > u8l1_pkg::OnesW'(MAX_SEQ_BYTES)) begin
                o_dec.emit              = 1'b1;
                o_dec.result.seq_length = u8l1_pkg::LenW'(1);
                o_dec.result.status     = u8l1_pkg::ST_TOO_LONG;
            end else begin
                n_total = u8l1_pkg::LenW'(w_ones);
                n_rem   = RemW'(w_ones - u8l1_pkg::OnesW'(1));
                n_acc   = i_byte & w_lead_mask;
                n_big   = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_acc   <= '0;
            r_big   <= 1'b0;
            r_total <= '0;
        end else if (i_adv) begin
            r_rem   <= n_rem;
            r_acc   <= n_acc;
            r_big   <= n_big;
            r_total <= n_total;
        end
    end

endmodule

// ===== rtl/core/u8l1_out_reg.sv =====
module u8l1_out_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  u8l1_pkg::t_dec_out i_dec,
    output logic               o_adv,
    u8l1_char_if.source        o_out
);

    logic              r_valid;
    u8l1_pkg::t_result r_res;
    logic              w_free;

    assign w_free = !r_valid || o_out.ready;
    assign o_adv  = i_valid && w_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_free) begin
            r_valid <= o_adv && i_dec.emit;
        end
        if (o_adv && i_dec.emit) begin
            r_res <= i_dec.result;
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.latin1_char = r_res.latin1_char;
    assign o_out.seq_length  = r_res.seq_length;
    assign o_out.status      = r_res.status;

endmodule

// ===== rtl/core/utf8_to_latin1_decoder.sv =====
// UTF-8 to Latin-1 decoder.
// Input channel i_in carries one raw UTF-8 byte per word (valid/ready).
// Output channel o_out carries one decoded word per finished sequence:
// latin1_char, seq_length (bytes consumed) and status (ok, lead too long,
// code point above 0xFF, stray continuation). Error words carry char zero.
// An ASCII byte or a lead-position error yields a word for that byte; a
// lead byte and the middle bytes of a sequence yield nothing until the
// last byte. Following bytes are not checked for their marker bits.
// The byte completing a sequence lands in the input register when it is
// accepted; its word is decoded into the result register once that stage
// is free, and o_out.valid then rises.
// Throughput: one byte per cycle while the result register is free, set by
// the single decode pass between the two registers; the decoder state
// updates as each byte leaves the input register.
// Reset (synchronous, i_rst_n low) empties both registers and returns the
// decoder to idle, waiting for a lead byte.
// When the receiver stalls, hold the result word; the input register still
// takes one byte and stalls after it, so one byte waits beside the word.
module utf8_to_latin1_decoder #(
    parameter int unsigned MAX_SEQ_BYTES = u8l1_pkg::MaxSeqBytesDefault
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8l1_byte_if.sink   i_in,
    u8l1_char_if.source o_out
);

    logic                       w_in_valid;
    logic [u8l1_pkg::ByteW-1:0] w_byte;
    logic                       w_adv;
    u8l1_pkg::t_dec_out         w_dec;

    // Input register: capture the byte, advance when the result stage frees.
    u8l1_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_adv   (w_adv),
        .o_valid (w_in_valid),
        .o_byte  (w_byte)
    );

    // Decode pass and sequence state; state steps only when the byte advances.
    u8l1_decode #(
        .MAX_SEQ_BYTES (MAX_SEQ_BYTES)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_byte  (w_byte),
        .o_dec   (w_dec)
    );

    // Result register: load a word only when the decode pass emits one.
    u8l1_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_in_valid),
        .i_dec   (w_dec),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );

endmodule

// ===== tb/utf8_to_latin1_decoder_checker.sv =====
module utf8_to_latin1_decoder_checker #(
    parameter int unsigned MAX_SEQ_BYTES = u8l1_pkg::MaxSeqBytesDefault
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    u8l1_byte_if  i_in,
    u8l1_char_if  i_out,
    output int    o_fail_count,
    output int    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Decoder state as the block should hold it.
    logic [1:0]  follow_left = '0;
    logic [20:0] code_acc    = '0;
    logic [2:0]  seq_total   = '0;

    u8l1_pkg::t_result char_q[$];
    int          fail_cnt    = 0;
    int          pend_cnt    = 0;

    assign o_fail_count = fail_cnt;
    assign o_pending    = pend_cnt;

    // Advance the decoder by one byte; return 1 when a word comes out of it.
    function automatic bit decode_byte(input logic [7:0] b, output u8l1_pkg::t_result r);
        int unsigned ones;
        logic [20:0] cp;
        r    = '0;
        ones = 0;
        if (follow_left != 2'd0) begin
            // Any byte counts as a follower here; only its low six bits matter.
            code_acc    = {code_acc[14:0], b[5:0]};
            follow_left = follow_left - 2'd1;
            if (follow_left != 2'd0) begin
                return 1'b0;
            end
            cp           = code_acc;
            r.seq_length = seq_total;
            code_acc     = '0;
            seq_total    = '0;
            if (cp > 21'h0000FF) begin
                r.status = u8l1_pkg::ST_ABOVE_FF;
            end else begin
                r.latin1_char = cp[7:0];
                r.status      = u8l1_pkg::ST_OK;
            end
            return 1'b1;
        end
        r.seq_length = 3'd1;
        if (!b[7]) begin
            r.latin1_char = b;
            r.status      = u8l1_pkg::ST_OK;
            return 1'b1;
        end
        while (ones < 8 && b[7 - ones]) begin
            ones++;
        end
        if (ones == 1) begin
            r.status = u8l1_pkg::ST_STRAY;
            return 1'b1;
        end
        if (ones > MAX_SEQ_BYTES) begin
            r.status = u8l1_pkg::ST_TOO_LONG;
            return 1'b1;
        end
        seq_total   = 3'(ones);
        follow_left = 2'(ones - 1);
        code_acc    = 21'(b & (8'h7F >> ones));
        return 1'b0;
    endfunction

    always @(posedge i_clk) begin : watch
        u8l1_pkg::t_result predicted;
        u8l1_pkg::t_result exp_w;
        if (!i_rst_n) begin
            follow_left = '0;
            code_acc    = '0;
            seq_total   = '0;
            char_q.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                if (decode_byte(i_in.byte_in, predicted)) begin
                    char_q.push_back(predicted);
                end
            end
            if (i_out.valid && i_out.ready) begin
                if (char_q.size() == 0) begin
                    $error("unexpected word: latin1_char %02h seq_length %0d status %0d",
                           i_out.latin1_char, i_out.seq_length, i_out.status);
                    fail_cnt++;
                end else begin
                    exp_w = char_q.pop_front();
                    if (exp_w.latin1_char !== i_out.latin1_char) begin
                        $error("latin1_char: expected %02h, got %02h",
                               exp_w.latin1_char, i_out.latin1_char);
                        fail_cnt++;
                    end
                    if (exp_w.seq_length !== i_out.seq_length) begin
                        $error("seq_length: expected %0d, got %0d",
                               exp_w.seq_length, i_out.seq_length);
                        fail_cnt++;
                    end
                    if (exp_w.status !== i_out.status) begin
                        $error("status: expected %0d, got %0d",
                               exp_w.status, i_out.status);
                        fail_cnt++;
                    end
                end
            end
        end
        pend_cnt = char_q.size();
    end

endmodule

// ===== tb/utf8_to_latin1_decoder_tb.sv =====
module utf8_to_latin1_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned TotalBytes    = 850;
    // Last stretch of the run goes without any idling on either side.
    localparam int unsigned CalmBytes     = 100;
    // Long receiver hold-off so the input side backs up and stalls.
    localparam int unsigned SqueezeCycles = 300;

    logic        i_clk;
    logic        i_rst_n;
    int          fail_count;
    int          pending;
    int unsigned bytes_sent  = 0;
    bit          calm        = 1'b0;
    bit          squeeze_req = 1'b0;

    u8l1_byte_if in_ch ();
    u8l1_char_if out_ch ();

    // Directed bytes: ASCII extremes, valid two- and three-byte sequences,
    // overlong three- and four-byte ones, code points just inside and just
    // past Latin-1, stray continuations, leads with too many ones, and bytes
    // of any kind taken as followers in the middle of a sequence.
    logic [7:0] directed_bytes [$] = '{
        8'h00, 8'h7F,
        8'hC3, 8'hA9,
        8'hC3, 8'hBF,
        8'hC4, 8'h80,
        8'hE0, 8'h82, 8'h80,
        8'hE2, 8'h82, 8'hAC,
        8'hF0, 8'h80, 8'h80, 8'hBF,
        8'h80,
        8'hF8,
        8'hFF,
        8'hC3, 8'h41,
        8'hC2, 8'hC3
    };

    utf8_to_latin1_decoder dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    utf8_to_latin1_decoder_checker chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Hard stop in case a handshake hangs.
    initial begin : watchdog
        #5ms;
        $display("utf8_to_latin1_decoder_tb: done, errors");
        $finish;
    end

    // Offer one byte, optionally after a random gap, and hold it until taken.
    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 18);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.byte_in <= b;
        do @(posedge i_clk); while (!in_ch.ready);
        bytes_sent++;
        calm = (bytes_sent + CalmBytes >= TotalBytes);
    endtask

    // Mostly well-formed sequences, with some kept inside Latin-1 so the
    // ok path gets exercised; the rest is raw noise and leads with random followers.
    task automatic send_sequence();
        int unsigned kind;
        int unsigned len;
        int unsigned k;
        bit          fit;
        logic [7:0]  lead;
        logic [7:0]  follow;
        kind = $urandom_range(0, 15);
        if (kind < 4) begin
            send_byte(8'($urandom_range(0, 127)));
        end else if (kind < 13) begin
            len = ($urandom_range(0, 1) == 0) ? 2 : $urandom_range(2, 4);
            fit = 1'($urandom_range(0, 1));
            case (len)
                2: begin
                    lead = fit ? {7'b1100001, 1'($urandom_range(0, 1))}
                               : {3'b110, 5'($urandom)};
                end
                3: begin
                    lead = {4'b1110, fit ? 4'h0 : 4'($urandom)};
                end
                default: begin
                    lead = {5'b11110, fit ? 3'b000 : 3'($urandom)};
                end
            endcase
            send_byte(lead);
            for (k = 1; k < len; k++) begin
                if (fit && k + 2 < len + 1 && k < len - 2) begin
                    follow = 8'h80;
                end else if (fit && k == len - 2) begin
                    follow = {6'b100000, 2'($urandom)};
                end else begin
                    follow = {2'b10, 6'($urandom)};
                end
                send_byte(follow);
            end
        end else if (kind < 15) begin
            send_byte(8'($urandom));
        end else begin
            // Lead byte followed by arbitrary bytes, markers not respected.
            len  = $urandom_range(2, 4);
            lead = (len == 2) ? {3'b110, 5'($urandom)}
                 : (len == 3) ? {4'b1110, 4'($urandom)}
                              : {5'b11110, 3'($urandom)};
            send_byte(lead);
            for (k = 1; k < len; k++) begin
                send_byte(8'($urandom));
            end
        end
    endtask

    // Receiver: random stall bursts, one long hold-off, steady at the end.
    initial begin : receiver
        int unsigned hold;
        bit          squeezed;
        squeezed = 1'b0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (squeeze_req && !squeezed) begin
                squeezed = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (SqueezeCycles) @(posedge i_clk);
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                hold = $urandom_range(1, 18);
                out_ch.ready <= 1'b0;
                repeat (hold - 1) @(posedge i_clk);
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        i_rst_n       <= 1'b0;
        in_ch.valid   <= 1'b0;
        in_ch.byte_in <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_bytes[i]) begin
            send_byte(directed_bytes[i]);
        end

        // Start the long hold-off while the random stream keeps coming.
        squeeze_req = 1'b1;
        while (bytes_sent < TotalBytes) begin
            send_sequence();
        end
        in_ch.valid <= 1'b0;

        // Drain: let the checker see the last byte, then wait out the pipe.
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("utf8_to_latin1_decoder_tb: done, clean");
        end else begin
            $display("utf8_to_latin1_decoder_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/u8l1_pkg.sv
rtl/core/u8l1_byte_if.sv
rtl/core/u8l1_char_if.sv
rtl/core/u8l1_in_reg.sv
rtl/core/u8l1_decode.sv
rtl/core/u8l1_out_reg.sv
rtl/core/utf8_to_latin1_decoder.sv
tb/utf8_to_latin1_decoder_checker.sv
tb/utf8_to_latin1_decoder_tb.sv
